FILE: rtl/core/ekd_pkg.sv
// Package: types, constants and helpers for the exponential kernel damping block.
`timescale 1ns / 1ps
package ekd_pkg;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_INIT   = 3'd1,
    KIND_TRIAL  = 3'd2,
    KIND_COMMIT = 3'd3,
    KIND_RESET  = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  localparam logic CFG_INITIAL_STEP   = 1'b0;
  localparam logic CFG_ACTIVE_KERNELS = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         kernel_index;
    logic signed [31:0] gain_real;
    logic signed [31:0] gain_imag;
    logic signed [31:0] pole_real;
    logic signed [31:0] pole_imag;
    logic signed [31:0] strain_rate;
    logic [30:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] stress;
    logic signed [31:0] damping_tangent;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_NUM,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_SUM,
    ST_FINISH,
    ST_COMMIT_A,
    ST_COMMIT_B,
    ST_SIMPLE,
    ST_OUT
  } state_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_DEN,
    OP_NUM,
    OP_DIV_SETUP,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_SUM,
    OP_FINISH,
    OP_COMMIT_A,
    OP_COMMIT_B,
    OP_SIMPLE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] kidx;
    logic [1:0] part;
  } dp_cmd_t;

  typedef struct packed {
    logic unchanged;
    logic div_done;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/core/ekd_ctrl.sv
// Controller: sequences kernel walks, divisions and commits.
`timescale 1ns / 1ps
module ekd_ctrl #(
  parameter int NUM_KERNELS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       kind_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ekd_pkg::dp_sts_t sts_i,
  output ekd_pkg::dp_cmd_t cmd_o
);
  import ekd_pkg::*;

  localparam int KW = (NUM_KERNELS > 1) ? $clog2(NUM_KERNELS) : 1;

  state_e     state_q, state_d;
  logic [2:0] kind_q, kind_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0] part_q, part_d;
  logic       val_q, val_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= '0;
      k_q     <= '0;
      part_q  <= '0;
      val_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      k_q     <= k_d;
      part_q  <= part_d;
      val_q   <= val_d;
    end
  end

  logic last_k;
  assign last_k = (32'(k_q) == NUM_KERNELS - 1);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    k_d     = k_q;
    part_d  = part_q;
    val_d   = val_q;
    cmd_o.op   = OP_NONE;
    cmd_o.kidx = 4'(k_q);
    cmd_o.part = part_q;
    in_stall_o = 1'b1;
    if (val_q && !out_stall_i) val_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = val_q;
        if (in_valid_i && !val_q) begin
          kind_d = kind_i;
          k_d    = '0;
          part_d = '0;
          cmd_o.op = OP_START;
          unique case (kind_i)
            KIND_LOAD: begin
              cmd_o.op = OP_LOAD;
              state_d  = ST_OUT;
            end
            KIND_INIT, KIND_TRIAL: state_d = ST_DEN;
            KIND_COMMIT: state_d = ST_COMMIT_A;
            default: state_d = ST_SIMPLE;
          endcase
        end
      end
      ST_DEN: begin
        if (kind_q == KIND_TRIAL && sts_i.unchanged) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.op = OP_DEN;
          state_d  = ST_NUM;
        end
      end
      ST_NUM: begin
        cmd_o.op = OP_NUM;
        part_d   = '0;
        state_d  = ST_DIV_SETUP;
      end
      ST_DIV_SETUP: begin
        cmd_o.op = OP_DIV_SETUP;
        state_d  = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_done) state_d = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        cmd_o.op = OP_DIV_STORE;
        // parts: 0 gain re, 1 gain im, 2 decay re, 3 decay im
        if ((kind_q == KIND_INIT && part_q == 2'd0) || part_q == 2'd3) begin
          part_d = '0;
          if (last_k) begin
            k_d     = '0;
            state_d = ST_SUM;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_DEN;
          end
        end else begin
          part_d  = part_q + 2'd1;
          state_d = ST_DIV_SETUP;
        end
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        if (last_k) state_d = ST_FINISH;
        else k_d = k_q + 1'b1;
      end
      ST_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = ST_OUT;
      end
      ST_COMMIT_A: begin
        cmd_o.op = OP_COMMIT_A;
        state_d  = ST_COMMIT_B;
      end
      ST_COMMIT_B: begin
        cmd_o.op = OP_COMMIT_B;
        if (last_k) begin
          k_d     = '0;
          state_d = ST_SIMPLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_COMMIT_A;
        end
      end
      ST_SIMPLE: begin
        cmd_o.op = OP_SIMPLE;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!val_d) begin
          val_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = val_q;

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni) val_q && out_stall_i |=> val_q;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_busy_stall;
    @(posedge clk_i) disable iff (!rst_ni) state_q != ST_IDLE |-> in_stall_o;
  endproperty
  a_busy_stall: assert property (p_busy_stall) else $error("accept while busy");

  property p_one_result;
    @(posedge clk_i) disable iff (!rst_ni) state_q == ST_OUT && !val_q |=> val_q;
  endproperty
  a_one_result: assert property (p_one_result) else $error("result not issued");

endmodule

FILE: rtl/core/ekd_datapath.sv
// Datapath: kernel tables, history, fixed-point multipliers and serial divider.
`timescale 1ns / 1ps
module ekd_datapath #(
  parameter int NUM_KERNELS = 4,
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ekd_pkg::in_item_t in_i,
  input  logic [30:0]      initial_step_i,
  input  logic [2:0]       active_kernels_i,
  input  ekd_pkg::dp_cmd_t cmd_i,
  output ekd_pkg::dp_sts_t sts_o,
  output ekd_pkg::out_item_t out_o
);
  import ekd_pkg::*;

  localparam int KW = (NUM_KERNELS > 1) ? $clog2(NUM_KERNELS) : 1;
  localparam int QB = 64 + FRAC_BITS;
  localparam int CW = $clog2(QB + 1);
  localparam logic signed [65:0] TWO  = 66'sd2 <<< FRAC_BITS;
  localparam logic signed [65:0] FOUR = 66'sd4 <<< FRAC_BITS;

  // Stores
  logic signed [31:0] gre_q [NUM_KERNELS], gim_q [NUM_KERNELS];
  logic signed [31:0] pre_q [NUM_KERNELS], pim_q [NUM_KERNELS];
  logic signed [31:0] mre_q [NUM_KERNELS], mim_q [NUM_KERNELS];
  logic signed [31:0] dre_q [NUM_KERNELS], dim_q [NUM_KERNELS];
  logic signed [31:0] sre_q [NUM_KERNELS], sim_q [NUM_KERNELS];
  logic signed [31:0] crate_q, trate_q, cstress_q, tstress_q;
  logic signed [31:0] ctan_q, ttan_q, itan_q;

  // Per-item work registers
  logic [2:0]         kind_q;
  logic signed [31:0] v_q;
  logic [30:0]        dt_q;
  logic signed [31:0] tre_q, tim_q, nre_q, nim_q, fre_q, fim_q;
  logic [63:0]        den_q;
  logic signed [65:0] msum_q, gsum_q;
  // memory*decay is kept at full width until the step term is added
  logic signed [65:0] zre_q, zim_q;

  // Divider
  logic [63:0] mag_q, r_q;
  logic [32:0] q_q;
  logic        neg_q, tz_q;
  logic [CW-1:0] cnt_q;

  logic [KW-1:0] k;
  assign k = cmd_i.kidx[KW-1:0];

  function automatic logic signed [65:0] fmul(input logic signed [31:0] x,
                                             input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    return 66'(p >>> FRAC_BITS);
  endfunction

  // Sign and magnitude of a sum of two 64-bit products
  function automatic logic [64:0] addmag(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
    logic signed [64:0] s;
    logic [64:0] m;
    s = 65'(a) + 65'(b);
    m = s[64] ? 65'(-s) : 65'(s);
    return {s[64], m[63:0]};
  endfunction

  logic [30:0] dt;
  assign dt = (kind_q == KIND_INIT) ? initial_step_i : dt_q;

  logic signed [31:0] dts;
  assign dts = $signed({1'b0, dt});

  logic n_act;
  assign n_act = (32'(active_kernels_i) > NUM_KERNELS) ? 1'b1
               : (32'(k) < 32'(active_kernels_i));

  // Divider operand selection
  logic signed [31:0] a_re, a_im;
  always_comb begin
    a_re = (cmd_i.part[1]) ? fre_q : nre_q;
    a_im = (cmd_i.part[1]) ? fim_q : nim_q;
  end
  logic [64:0] am;
  always_comb begin
    if (!cmd_i.part[0]) am = addmag(64'(a_re) * 64'(tre_q), 64'(a_im) * 64'(tim_q));
    else am = addmag(64'(a_im) * 64'(tre_q), -(64'(a_re) * 64'(tim_q)));
  end

  // Step cnt_q consumes dividend bit cnt_q-1 of mag_q scaled by 2^FRAC_BITS
  logic [63:0] r_sh;
  logic        carry, rbit, take;
  assign carry = r_q[63];
  assign rbit  = (32'(cnt_q) > FRAC_BITS) ? mag_q[6'(32'(cnt_q) - FRAC_BITS - 1)] : 1'b0;
  assign r_sh  = {r_q[62:0], rbit};
  assign take  = carry || (r_sh >= den_q);

  logic signed [31:0] qres;
  always_comb begin
    if (tz_q) qres = '0;
    else if (neg_q) qres = (q_q > 33'h080000000) ? 32'sh80000000 : 32'(-$signed(q_q));
    else qres = (q_q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : q_q[31:0];
  end

  logic signed [31:0] vs_c;
  assign vs_c = sat32(66'(crate_q) + 66'(trate_q));

  always_comb begin
    sts_o.unchanged = (v_q == crate_q);
    sts_o.div_done  = (cnt_q == '0);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KERNELS; i++) begin
        gre_q[i] <= '0; gim_q[i] <= '0; pre_q[i] <= '0; pim_q[i] <= '0;
        mre_q[i] <= '0; mim_q[i] <= '0; dre_q[i] <= '0; dim_q[i] <= '0;
        sre_q[i] <= '0; sim_q[i] <= '0;
      end
      crate_q <= '0; trate_q <= '0; cstress_q <= '0; tstress_q <= '0;
      ctan_q <= '0; ttan_q <= '0; itan_q <= '0;
      kind_q <= '0;
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (32'(in_i.kernel_index) < NUM_KERNELS) begin
            gre_q[KW'(in_i.kernel_index)] <= in_i.gain_real;
            gim_q[KW'(in_i.kernel_index)] <= in_i.gain_imag;
            pre_q[KW'(in_i.kernel_index)] <= in_i.pole_real;
            pim_q[KW'(in_i.kernel_index)] <= in_i.pole_imag;
          end
        end
        OP_START: begin
          kind_q <= in_i.kind;
          if (in_i.kind == KIND_INIT) begin
            for (int i = 0; i < NUM_KERNELS; i++) begin
              mre_q[i] <= '0; mim_q[i] <= '0; dre_q[i] <= '0; dim_q[i] <= '0;
              sre_q[i] <= '0; sim_q[i] <= '0;
            end
          end
          if (in_i.kind == KIND_TRIAL) trate_q <= in_i.strain_rate;
        end
        OP_DIV_SETUP: cnt_q <= CW'(QB);
        OP_DIV_STEP: if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        OP_DIV_STORE: begin
          // initialize only sums its gains; the step gains stay wiped
          if (kind_q != KIND_INIT) begin
            unique case (cmd_i.part)
              2'd0: sre_q[k] <= qres;
              2'd1: sim_q[k] <= qres;
              2'd2: dre_q[k] <= qres;
              default: dim_q[k] <= qres;
            endcase
          end
        end
        OP_FINISH: begin
          ttan_q <= sat32(gsum_q);
          if (kind_q == KIND_INIT) begin
            itan_q  <= sat32(gsum_q);
            ctan_q  <= sat32(gsum_q);
            trate_q <= '0;
            crate_q <= '0;
          end else begin
            tstress_q <= sat32(msum_q + fmul(sat32(gsum_q), vs_c));
          end
        end
        OP_COMMIT_B: begin
          mre_q[k] <= sat32(zre_q + fmul(sre_q[k], vs_c));
          mim_q[k] <= sat32(zim_q + fmul(sim_q[k], vs_c));
        end
        OP_SIMPLE: begin
          if (kind_q == KIND_COMMIT) begin
            crate_q <= trate_q; cstress_q <= tstress_q; ctan_q <= ttan_q;
          end else if (kind_q == KIND_RESET) begin
            trate_q <= crate_q; tstress_q <= cstress_q; ttan_q <= ctan_q;
          end else if (kind_q == KIND_CLEAR) begin
            for (int i = 0; i < NUM_KERNELS; i++) begin
              mre_q[i] <= '0; mim_q[i] <= '0; dre_q[i] <= '0; dim_q[i] <= '0;
              sre_q[i] <= '0; sim_q[i] <= '0;
            end
            crate_q <= '0; cstress_q <= '0; ctan_q <= itan_q;
            trate_q <= '0; tstress_q <= '0; ttan_q <= itan_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        v_q <= in_i.strain_rate;
        dt_q <= in_i.time_step;
        msum_q <= '0;
        gsum_q <= '0;
      end
      OP_DEN: begin
        tre_q <= sat32(TWO + 66'(sat32(fmul(dts, pre_q[k]))));
        tim_q <= sat32(fmul(dts, pim_q[k]));
      end
      OP_NUM: begin
        nre_q <= sat32(fmul(dts, gre_q[k]));
        nim_q <= sat32(fmul(dts, gim_q[k]));
        fre_q <= sat32(FOUR - 66'(tre_q));
        fim_q <= sat32(-66'(tim_q));
        den_q <= 64'(tre_q * tre_q) + 64'(tim_q * tim_q);
      end
      OP_DIV_SETUP: begin
        tz_q  <= (tre_q == '0) && (tim_q == '0);
        neg_q <= am[64];
        mag_q <= am[63:0];
        r_q   <= '0;
        q_q   <= '0;
      end
      OP_DIV_STEP: begin
        if (cnt_q != '0) begin
          r_q <= take ? r_sh - den_q : r_sh;
          q_q <= (q_q[32] ? q_q : {q_q[31:0], 1'b0}) | {32'd0, take};
        end
      end
      OP_DIV_STORE: begin
        if (kind_q == KIND_INIT && n_act) gsum_q <= gsum_q + 66'(qres);
      end
      OP_SUM: begin
        if (n_act) begin
          msum_q <= msum_q + fmul(mre_q[k], dre_q[k]) - fmul(mim_q[k], dim_q[k]);
          gsum_q <= gsum_q + 66'(sre_q[k]);
        end
      end
      OP_COMMIT_A: begin
        zre_q <= fmul(mre_q[k], dre_q[k]) - fmul(mim_q[k], dim_q[k]);
        zim_q <= fmul(mre_q[k], dim_q[k]) + fmul(mim_q[k], dre_q[k]);
      end
      default: ;
    endcase
  end

  assign out_o.stress          = tstress_q;
  assign out_o.damping_tangent = ttan_q;

endmodule

FILE: rtl/core/exponential_kernel_damping_update.sv
// Top level of the exponential kernel damping update block.
`timescale 1ns / 1ps
// Usage:
//  Input channel in_valid_i / in_stall_o carries one transaction per item:
//  kind, kernel slot, kernel gain and pole, strain rate and time step.
//  Each accepted transaction yields exactly one result transaction on
//  out_valid_o / out_stall_i carrying trial stress and damping tangent.
//  Configuration: cfg_we_i writes initial_step (index 0) or active_kernels
//  (index 1); the user must do so only while the block is idle, which the
//  block itself does not enforce. A load goes straight to the result; reset,
//  clear and unused kinds pass through the simple step; a trial with an
//  unchanged rate ends at its first denominator check; commit runs steps A
//  and B for each kernel, then the simple step. Trial and initialize run a
//  (64+FRAC_BITS)-step restoring divider and, per kernel, form denominator
//  and numerator, then set up, run and store each quotient part: four parts
//  per kernel for a trial, one for initialize; then they sum the kernels and
//  finish. The serial divider sets the rate; one item at a time, the next
//  taken the cycle after the result is taken. Reset clears all tables and
//  history to zero and restores register defaults. While the receiver
//  stalls, the result register holds and no new transaction is taken.
module exponential_kernel_damping_update #(
  parameter int NUM_KERNELS = 4,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ekd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ekd_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [30:0]        cfg_data_i
);
  import ekd_pkg::*;

  logic [30:0] init_step_q;
  logic [2:0]  act_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_step_q <= 31'd65536;
      act_q       <= 3'd4;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_INITIAL_STEP) init_step_q <= cfg_data_i;
      else act_q <= cfg_data_i[2:0];
    end
  end

  ekd_ctrl #(.NUM_KERNELS(NUM_KERNELS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .kind_i(in_data_i.kind), .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ekd_datapath #(.NUM_KERNELS(NUM_KERNELS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .initial_step_i(init_step_q),
    .active_kernels_i(act_q), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );

endmodule
